// ===== sv/m4te_pkg.sv =====
// Shared types, constants and the fixed-point saturation helper of the 4x4 matrix transform engine.
package m4te_pkg;

	localparam int FracBits = 16;
	localparam logic [31:0] One = 32'(1) << FracBits;

	typedef enum logic [1:0] {
		KindWrCur   = 2'd0,
		KindWrOp    = 2'd1,
		KindCompose = 2'd2,
		KindXform   = 2'd3
	} kind_t;

	// four Q16.16 lanes, lane 0 in the low bits
	typedef logic [3:0][31:0] vec4_t;

	// travels with each dot product through the datapath
	typedef struct packed {
		logic       xform;
		logic       last;
		logic [1:0] row;
		logic [1:0] lane;
	} dot_tag_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] s);
		logic [31:0] r;
		if (s > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -64'sh0000_0000_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/m4te_if.sv =====
// Handshake channels of the matrix transform engine: command in, vector result out.
interface m4te_req_if import m4te_pkg::*;;
	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] elem_value;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] vec_w;

	modport source (
		output valid, kind, row, col, elem_value, vec_x, vec_y, vec_z, vec_w,
		input  ready
	);
	modport sink (
		input  valid, kind, row, col, elem_value, vec_x, vec_y, vec_z, vec_w,
		output ready
	);
endinterface

interface m4te_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;

	modport source (output valid, out_x, out_y, out_z, out_w, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// ===== sv/m4te_dot.sv =====
// Four-lane fixed-point dot product: registered multiplies, then shifted sum and saturation.
module m4te_dot import m4te_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  vec4_t       a,
	input  vec4_t       b,
	input  dot_tag_t    tag,
	output logic        res_valid,
	output logic [31:0] res,
	output dot_tag_t    res_tag
);

	logic signed [63:0] prod_s1 [4];
	logic               valid_s1;
	dot_tag_t           tag_s1;
	logic [31:0]        res_s2;
	logic               valid_s2;
	dot_tag_t           tag_s2;
	logic signed [63:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= $signed(a[k]) * $signed(b[k]);
		end
		tag_s1 <= tag;
		res_s2 <= sat32(sum);
		tag_s2 <= tag_s1;
	end

	// arithmetic shift floors each term, as the fixed-point format requires
	always_comb begin
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			sum = sum + (prod_s1[k] >>> FracBits);
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;
	assign res_tag   = tag_s2;

endmodule

// ===== sv/matrix4_transform_engine.sv =====
// Top level of the 4x4 matrix transform engine: matrix memories, sequencer and result register.
//
//   port  | dir | transfer moves
//   ------+-----+-------------------------------------------------------------
//   req   | in  | kind, row, col, elem_value, vec_x..vec_w (one command)
//   rsp   | out | out_x..out_w (one transformed vector, for transforms only)
//
// An element write is stored when it is accepted. Transforms and composes run in steps:
// each step reads one row of the current matrix (and one column of the operand
// matrix) from its memory, and one dot product issues per cycle.
// Both matrices read as identity after reset, through per-element valid bits.
// A finished vector waits in the result register while the next command is taken;
// a second vector stalls the sequencer until the first is transferred.
module matrix4_transform_engine import m4te_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	m4te_req_if.sink   req,
	m4te_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		StIdle  = 4'b0001,
		StRun   = 4'b0010,
		StDrain = 4'b0100,
		StOut   = 4'b1000
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       xform_q;
	vec4_t      vec_q;

	// current matrix stored by rows, operand matrix by columns
	vec4_t            cur_mem [4];
	vec4_t            op_mem [4];
	logic [3:0][3:0]  cur_vld_q;
	logic [3:0][3:0]  op_vld_q;

	logic       accept;
	logic       issue;
	logic       last_issue;
	logic [1:0] rd_row;
	logic [1:0] rd_col;

	logic       v_s1;
	dot_tag_t   tag_s1;
	vec4_t      cur_rd_s1;
	vec4_t      op_rd_s1;
	logic [3:0] cur_vld_s1;
	logic [3:0] op_vld_s1;

	vec4_t       opa;
	vec4_t       opb;
	dot_tag_t    issue_tag;
	logic        dv;
	logic [31:0] dsum;
	dot_tag_t    dtag;

	vec4_t      buf_q;
	logic       wb;
	logic [3:0] cur_we;
	logic [1:0] cur_waddr;
	vec4_t      cur_wdata;
	logic       op_we;

	logic  out_v_q;
	vec4_t out_q;
	logic  out_load;

	assign req.ready = (state_q == StIdle);
	assign accept    = req.valid && req.ready;
	assign issue     = (state_q == StRun);
	assign rd_row    = xform_q ? step_q[1:0] : step_q[3:2];
	assign rd_col    = step_q[1:0];
	assign last_issue = xform_q ? (step_q[1:0] == 2'd3) : (step_q == 4'hF);

	always_comb begin
		issue_tag.xform = xform_q;
		issue_tag.last  = last_issue;
		issue_tag.row   = rd_row;
		issue_tag.lane  = xform_q ? step_q[1:0] : rd_col;
	end

	// write port of the current matrix: host element write or compose row write-back
	assign wb = dv && !dtag.xform && (dtag.lane == 2'd3);
	always_comb begin
		cur_we    = '0;
		cur_waddr = req.row;
		cur_wdata = {4{req.elem_value}};
		if (wb) begin
			cur_we    = 4'hF;
			cur_waddr = dtag.row;
			cur_wdata = {dsum, buf_q[2], buf_q[1], buf_q[0]};
		end else if (accept && req.kind == KindWrCur) begin
			cur_we[req.col] = 1'b1;
		end
	end
	assign op_we = accept && (req.kind == KindWrOp);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (cur_we[k]) begin
				cur_mem[cur_waddr][k] <= cur_wdata[k];
			end
		end
		if (op_we) begin
			op_mem[req.col][req.row] <= req.elem_value;
		end
		if (issue) begin
			cur_rd_s1  <= cur_mem[rd_row];
			op_rd_s1   <= op_mem[rd_col];
			cur_vld_s1 <= cur_vld_q[rd_row];
			op_vld_s1  <= op_vld_q[rd_col];
			tag_s1     <= issue_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= '0;
			op_vld_q  <= '0;
		end else begin
			for (int k = 0; k < 4; k++) begin
				if (cur_we[k]) begin
					cur_vld_q[cur_waddr][k] <= 1'b1;
				end
			end
			if (op_we) begin
				op_vld_q[req.col][req.row] <= 1'b1;
			end
		end
	end

	// unwritten elements read as identity
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (cur_vld_s1[k]) begin
				opa[k] = cur_rd_s1[k];
			end else begin
				opa[k] = (tag_s1.row == 2'(k)) ? One : '0;
			end
			if (tag_s1.xform) begin
				opb[k] = vec_q[k];
			end else if (op_vld_s1[k]) begin
				opb[k] = op_rd_s1[k];
			end else begin
				opb[k] = (tag_s1.lane == 2'(k)) ? One : '0;
			end
		end
	end

	m4te_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (v_s1),
		.a         (opa),
		.b         (opb),
		.tag       (tag_s1),
		.res_valid (dv),
		.res       (dsum),
		.res_tag   (dtag)
	);

	// collect one row of a compose, or the four lanes of a transform
	always_ff @(posedge clk) begin
		if (dv) begin
			buf_q[dtag.lane] <= dsum;
		end
		if (accept && req.kind == KindXform) begin
			vec_q <= {req.vec_w, req.vec_z, req.vec_y, req.vec_x};
		end
		if (out_load) begin
			out_q <= buf_q;
		end
	end

	assign out_load = (state_q == StOut) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			step_q  <= '0;
			xform_q <= 1'b0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (accept && (req.kind == KindCompose || req.kind == KindXform)) begin
						state_q <= StRun;
						step_q  <= '0;
						xform_q <= (req.kind == KindXform);
					end
				end
				StRun: begin
					step_q <= step_q + 4'd1;
					if (last_issue) begin
						state_q <= StDrain;
					end
				end
				StDrain: begin
					if (dv && dtag.last) begin
						state_q <= dtag.xform ? StOut : StIdle;
					end
				end
				StOut: begin
					if (out_load) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.out_x = out_q[0];
	assign rsp.out_y = out_q[1];
	assign rsp.out_z = out_q[2];
	assign rsp.out_w = out_q[3];

endmodule

// ===== tb/sv/m4te_tb_pkg.sv =====
// Command record and vector scoreboard used by the matrix transform engine testbench.
package m4te_tb_pkg;
	import m4te_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] elem;
		vec4_t       vec;
	} m4te_cmd_t;

	class m4te_vector_scoreboard;
		logic signed [31:0] cur_m [16];
		logic signed [31:0] op_m [16];
		vec4_t expected_vectors [$];
		int errors;
		int vectors_checked;
		int n_writes;
		int n_composes;
		int n_xforms;

		function new();
			for (int i = 0; i < 16; i++) begin
				cur_m[i] = (i % 5 == 0) ? One : 32'sd0;
				op_m[i] = (i % 5 == 0) ? One : 32'sd0;
			end
		endfunction

		// row r of the current matrix dotted with b: floor-shifted terms, saturated sum
		function logic signed [31:0] dot_q16(int r, logic signed [31:0] b [4]);
			logic signed [63:0] acc;
			logic signed [63:0] lhs;
			logic signed [63:0] rhs;
			acc = 0;
			for (int k = 0; k < 4; k++) begin
				lhs = cur_m[r * 4 + k];
				rhs = b[k];
				acc += (lhs * rhs) >>> FracBits;
			end
			if (acc > 64'sh0000_0000_7FFF_FFFF) begin
				return 32'sh7FFF_FFFF;
			end else if (acc < 64'shFFFF_FFFF_8000_0000) begin
				return 32'sh8000_0000;
			end
			return acc[31:0];
		endfunction

		function void note_command(m4te_cmd_t c);
			logic signed [31:0] b [4];
			logic signed [31:0] tmp [16];
			vec4_t res;
			case (c.kind)
				KindWrCur: begin
					cur_m[{c.row, c.col}] = c.elem;
					n_writes++;
				end
				KindWrOp: begin
					op_m[{c.row, c.col}] = c.elem;
					n_writes++;
				end
				KindCompose: begin
					for (int i = 0; i < 4; i++) begin
						for (int j = 0; j < 4; j++) begin
							for (int k = 0; k < 4; k++) b[k] = op_m[k * 4 + j];
							tmp[i * 4 + j] = dot_q16(i, b);
						end
					end
					cur_m = tmp;
					n_composes++;
				end
				default: begin
					for (int k = 0; k < 4; k++) b[k] = c.vec[k];
					for (int i = 0; i < 4; i++) res[i] = dot_q16(i, b);
					expected_vectors.push_back(res);
					n_xforms++;
				end
			endcase
		endfunction

		function void check_vector(vec4_t got);
			vec4_t want;
			string lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};
			if (expected_vectors.size() == 0) begin
				$error("vector result with no transform outstanding: %h", got);
				errors++;
				return;
			end
			want = expected_vectors.pop_front();
			vectors_checked++;
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== want[i]) begin
					$error("%s mismatch: expected %h, got %h", lane_name[i], want[i], got[i]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_vectors.size();
		endfunction
	endclass

endpackage

// ===== tb/sv/matrix4_transform_engine_test.sv =====
// Top-level testbench of the matrix transform engine: stimulus, result sink and run control.
module matrix4_transform_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import m4te_pkg::*;
	import m4te_tb_pkg::*;

	logic clk;
	logic arst_n;

	m4te_req_if req_ch();
	m4te_rsp_if rsp_ch();

	matrix4_transform_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	m4te_vector_scoreboard sb = new();

	int phase;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rand_q16();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) return 32'(int'($urandom_range(262143)) - 131072);
		if (pick < 55) return 32'(int'(One) + int'($urandom_range(8191)) - 4096);
		if (pick < 65) return 32'h0;
		if (pick < 75) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom();
	endfunction

	function automatic m4te_cmd_t rand_cmd();
		m4te_cmd_t c;
		int pick;
		c.row = 2'($urandom());
		c.col = 2'($urandom());
		c.elem = rand_q16();
		for (int k = 0; k < 4; k++) c.vec[k] = rand_q16();
		pick = $urandom_range(99);
		if (pick < 68) c.kind = KindXform;
		else if (pick < 80) c.kind = KindWrCur;
		else if (pick < 93) c.kind = KindWrOp;
		else c.kind = KindCompose;
		return c;
	endfunction

	function automatic m4te_cmd_t wr_cmd(kind_t kind, logic [1:0] row, logic [1:0] col,
			logic [31:0] value);
		m4te_cmd_t c;
		c = '0;
		c.kind = kind;
		c.row = row;
		c.col = col;
		c.elem = value;
		return c;
	endfunction

	function automatic m4te_cmd_t xf_cmd(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] w);
		m4te_cmd_t c;
		c = '0;
		c.kind = KindXform;
		c.vec = {w, z, y, x};
		return c;
	endfunction

	task automatic send_cmd(m4te_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= c.kind;
		req_ch.row <= c.row;
		req_ch.col <= c.col;
		req_ch.elem_value <= c.elem;
		req_ch.vec_x <= c.vec[0];
		req_ch.vec_y <= c.vec[1];
		req_ch.vec_z <= c.vec[2];
		req_ch.vec_w <= c.vec[3];
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_command(c);
	endtask

	task automatic send_random(int count);
		for (int n = 0; n < count; n++) send_cmd(rand_cmd());
	endtask

	task automatic run_directed();
		// identity after reset passes the vector through, extremes included
		send_cmd(xf_cmd(32'h0001_0000, 32'hFFFE_8000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_cmd(wr_cmd(KindWrCur, 2'd0, 2'd0, 32'h7FFF_FFFF));
		send_cmd(wr_cmd(KindWrCur, 2'd0, 2'd1, 32'h7FFF_FFFF));
		send_cmd(wr_cmd(KindWrCur, 2'd1, 2'd0, 32'h8000_0000));
		send_cmd(wr_cmd(KindWrCur, 2'd1, 2'd1, 32'h7FFF_FFFF));
		// saturate high on row 0, low on row 1
		send_cmd(xf_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0));
		send_cmd(xf_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
		send_cmd(xf_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		// tiny negative products must round toward minus infinity
		send_cmd(wr_cmd(KindWrCur, 2'd2, 2'd2, 32'h0000_0001));
		send_cmd(xf_cmd(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// give the fourth row its own values
		send_cmd(wr_cmd(KindWrCur, 2'd3, 2'd0, 32'h0003_0000));
		send_cmd(wr_cmd(KindWrCur, 2'd3, 2'd1, 32'hFFFF_0000));
		send_cmd(wr_cmd(KindWrCur, 2'd3, 2'd3, 32'h0000_8000));
		send_cmd(xf_cmd(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
		send_cmd(wr_cmd(KindWrOp, 2'd3, 2'd0, 32'h0002_0000));
		send_cmd(wr_cmd(KindWrOp, 2'd0, 2'd3, 32'hFFFF_8000));
		send_cmd(wr_cmd(KindWrOp, 2'd2, 2'd1, 32'h8000_0000));
		send_cmd(wr_cmd(KindWrOp, 2'd3, 2'd3, 32'h7FFF_FFFF));
		send_cmd(wr_cmd(KindCompose, 2'd0, 2'd0, 32'h0));
		send_cmd(xf_cmd(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000));
		send_cmd(wr_cmd(KindCompose, 2'd3, 2'd3, 32'hFFFF_FFFF));
		send_cmd(xf_cmd(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
	endtask

	// result sink: check each transfer, then pick ready for the next edge
	initial begin
		rsp_ch.ready <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_vector({rsp_ch.out_w, rsp_ch.out_z, rsp_ch.out_y, rsp_ch.out_x});
			end
			// stall results for a long stretch once, so the input side backs up
			if (phase == 2 && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int wait_cycles;
		phase = 0;
		send_idle_pct = 33;
		recv_idle_pct = 79;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KindWrCur;
		req_ch.row <= 2'd0;
		req_ch.col <= 2'd0;
		req_ch.elem_value <= 32'sd0;
		req_ch.vec_x <= 32'sd0;
		req_ch.vec_y <= 32'sd0;
		req_ch.vec_z <= 32'sd0;
		req_ch.vec_w <= 32'sd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		send_random(600);

		phase = 1;
		send_idle_pct = 79;
		recv_idle_pct = 33;
		send_random(600);

		phase = 2;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(550);
		req_ch.valid <= 1'b0;

		for (wait_cycles = 0; sb.pending() != 0 && wait_cycles < 20000; wait_cycles++) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d transform results never arrived", sb.pending());
			sb.errors++;
		end

		$display("Run covered %0d element writes, %0d composes and %0d transforms;",
			sb.n_writes, sb.n_composes, sb.n_xforms);
		$display("%0d result vectors compared under mixed, reversed and no-idle traffic.",
			sb.vectors_checked);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: run did not finish");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
